// ===== src/record_table_sort_desc_defines.svh =====
// assertion macros for the record table
`ifndef RECORD_TABLE_SORT_DESC_DEFINES_SVH
`define RECORD_TABLE_SORT_DESC_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define RTSD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("record table assertion failed");

// consequent must hold in the cycle after the antecedent
`define RTSD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("record table assertion failed");

`endif

// ===== src/rtsd_pkg.sv =====
// types, constants and codes shared by the record table modules
package rtsd_pkg;

  localparam int DEPTH      = 16;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W     = $clog2(DEPTH + 1);
  localparam int CNT_W      = FILL_W + 1;
  localparam int TOTAL_W    = 5;
  localparam int POS_W      = 4;
  localparam int POS_CMP_W  = (FILL_W > POS_W) ? FILL_W : POS_W;
  localparam int ID_W       = 32;
  localparam int DAY_W      = 32;
  localparam int BUYER_W    = 16;
  localparam int AMT_W      = 40;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_SORT   = 2'd2,
    REQ_READ   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_INS_HEAD,
    S_DEL_RD,
    S_DEL_CHK,
    S_DEL_MVR,
    S_DEL_MVW,
    S_SRT_RD,
    S_SRT_CMP,
    S_SRT_WR2,
    S_RD_WAIT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [DAY_W-1:0]   day;
    logic [BUYER_W-1:0] buyer;
    logic               paid;
    logic [AMT_W-1:0]   amount;
  } rec_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    rec_t              data;
  } wr_t;

  typedef struct packed {
    logic b_gt_a;
    logic id_eq;
  } cmp_t;

  typedef struct packed {
    status_e           status;
    logic [FILL_W-1:0] total;
    rec_t              rec;
  } res_t;

endpackage

// ===== src/rtsd_store.sv =====
// record memory: one write port, two registered read ports
module rtsd_store (
  input  logic                       clk_i,
  input  rtsd_pkg::wr_t              wr_i,
  input  logic [rtsd_pkg::ADDR_W-1:0] ra_i,
  input  logic [rtsd_pkg::ADDR_W-1:0] rb_i,
  output rtsd_pkg::rec_t             rd_a_o,
  output rtsd_pkg::rec_t             rd_b_o
);
  import rtsd_pkg::*;

  rec_t mem [DEPTH];
  rec_t rd_a_q;
  rec_t rd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_a_q <= mem[ra_i];
    rd_b_q <= mem[rb_i];
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

// ===== src/rtsd_cmp.sv =====
// shared compare unit: amount order and id match
module rtsd_cmp (
  input  rtsd_pkg::rec_t            rec_a_i,
  input  rtsd_pkg::rec_t            rec_b_i,
  input  logic [rtsd_pkg::ID_W-1:0] key_i,
  output rtsd_pkg::cmp_t            cmp_o
);
  import rtsd_pkg::*;

  // unsigned amount compare, equality on raw id bits
  always_comb begin
    cmp_o.b_gt_a = (rec_b_i.amount > rec_a_i.amount);
    cmp_o.id_eq  = (rec_a_i.id == key_i);
  end

endmodule

// ===== src/rtsd_ctrl.sv =====
// sequencer: insert shift, delete search and close-up, sort passes, read
module rtsd_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  rtsd_pkg::req_e              req_i,
  input  rtsd_pkg::rec_t              rec_i,
  input  logic [rtsd_pkg::POS_W-1:0]  pos_i,
  output rtsd_pkg::wr_t               wr_o,
  output logic [rtsd_pkg::ADDR_W-1:0] ra_o,
  output logic [rtsd_pkg::ADDR_W-1:0] rb_o,
  input  rtsd_pkg::rec_t              rd_a_i,
  input  rtsd_pkg::rec_t              rd_b_i,
  output logic [rtsd_pkg::ID_W-1:0]   key_o,
  input  rtsd_pkg::cmp_t              cmp_i,
  input  logic                        out_free_i,
  output logic                        done_o,
  output rtsd_pkg::res_t              res_o
);
  import rtsd_pkg::*;

  state_e            state_q, state_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0]  a_q, a_d;
  logic [CNT_W-1:0]  b_q, b_d;
  logic [CNT_W-1:0]  pass_q, pass_d;
  logic              odd_q, odd_d;
  status_e           status_q, status_d;
  rec_t              rec_in_q, rec_in_d;
  rec_t              tmp_q, tmp_d;
  rec_t              res_rec_q, res_rec_d;

  logic [CNT_W-1:0]  n;
  logic              adv_more;
  logic [CNT_W-1:0]  adv_a, adv_b, adv_pass;

  assign n     = CNT_W'(fill_q);
  assign key_o = rec_in_q.id;

  // next compare pair of the running sort
  always_comb begin
    adv_more = 1'b1;
    adv_a    = a_q;
    adv_b    = b_q;
    adv_pass = pass_q;
    if (b_q + CNT_W'(1) < n) begin
      adv_b = b_q + CNT_W'(1);
      if (!odd_q) begin
        adv_a = a_q + CNT_W'(1);
      end
    end else if (!odd_q && (pass_q + CNT_W'(1) < n)) begin
      adv_pass = pass_q + CNT_W'(1);
      adv_a    = '0;
      adv_b    = CNT_W'(1);
    end else if (odd_q && (a_q + CNT_W'(2) < n)) begin
      adv_a = a_q + CNT_W'(1);
      adv_b = a_q + CNT_W'(2);
    end else begin
      adv_more = 1'b0;
    end
  end

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    a_d        = a_q;
    b_d        = b_q;
    pass_d     = pass_q;
    odd_d      = odd_q;
    status_d   = status_q;
    rec_in_d   = rec_in_q;
    tmp_d      = tmp_q;
    res_rec_d  = res_rec_q;
    wr_o       = '0;
    ra_o       = a_q[ADDR_W-1:0];
    rb_o       = b_q[ADDR_W-1:0];
    in_ready_o = (state_q == S_IDLE);
    done_o     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          rec_in_d  = rec_i;
          status_d  = ST_OK;
          res_rec_d = '0;
          case (req_i)
            REQ_INSERT: begin
              if (fill_q == FILL_W'(DEPTH)) begin
                status_d = ST_FULL;
                state_d  = S_DONE;
              end else begin
                a_d     = n;
                state_d = (fill_q == '0) ? S_INS_HEAD : S_INS_RD;
              end
            end
            REQ_DELETE: begin
              if (fill_q == '0) begin
                status_d = ST_NOT_FOUND;
                state_d  = S_DONE;
              end else begin
                a_d     = '0;
                state_d = S_DEL_RD;
              end
            end
            REQ_SORT: begin
              if (n < CNT_W'(2)) begin
                state_d = S_DONE;
              end else begin
                odd_d   = fill_q[0];
                a_d     = '0;
                b_d     = CNT_W'(1);
                pass_d  = CNT_W'(1);
                state_d = S_SRT_RD;
              end
            end
            REQ_READ: begin
              if (POS_CMP_W'(pos_i) >= POS_CMP_W'(fill_q)) begin
                status_d = ST_EMPTY;
                state_d  = S_DONE;
              end else begin
                ra_o    = ADDR_W'(POS_CMP_W'(pos_i));
                state_d = S_RD_WAIT;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_INS_RD: begin
        ra_o    = ADDR_W'(a_q - CNT_W'(1));
        state_d = S_INS_WR;
      end
      S_INS_WR: begin
        wr_o.en   = 1'b1;
        wr_o.addr = a_q[ADDR_W-1:0];
        wr_o.data = rd_a_i;
        a_d       = a_q - CNT_W'(1);
        state_d   = (a_q == CNT_W'(1)) ? S_INS_HEAD : S_INS_RD;
      end
      S_INS_HEAD: begin
        wr_o.en   = 1'b1;
        wr_o.addr = '0;
        wr_o.data = rec_in_q;
        fill_d    = fill_q + FILL_W'(1);
        state_d   = S_DONE;
      end
      S_DEL_RD: begin
        state_d = S_DEL_CHK;
      end
      S_DEL_CHK: begin
        if (cmp_i.id_eq) begin
          if (a_q + CNT_W'(1) == n) begin
            fill_d  = fill_q - FILL_W'(1);
            state_d = S_DONE;
          end else begin
            state_d = S_DEL_MVR;
          end
        end else if (a_q + CNT_W'(1) == n) begin
          status_d = ST_NOT_FOUND;
          state_d  = S_DONE;
        end else begin
          a_d     = a_q + CNT_W'(1);
          state_d = S_DEL_RD;
        end
      end
      S_DEL_MVR: begin
        ra_o    = ADDR_W'(a_q + CNT_W'(1));
        state_d = S_DEL_MVW;
      end
      S_DEL_MVW: begin
        wr_o.en   = 1'b1;
        wr_o.addr = a_q[ADDR_W-1:0];
        wr_o.data = rd_a_i;
        a_d       = a_q + CNT_W'(1);
        if (a_q + CNT_W'(2) == n) begin
          fill_d  = fill_q - FILL_W'(1);
          state_d = S_DONE;
        end else begin
          state_d = S_DEL_MVR;
        end
      end
      S_SRT_RD: begin
        state_d = S_SRT_CMP;
      end
      S_SRT_CMP: begin
        if (cmp_i.b_gt_a) begin
          wr_o.en   = 1'b1;
          wr_o.addr = a_q[ADDR_W-1:0];
          wr_o.data = rd_b_i;
          tmp_d     = rd_a_i;
          state_d   = S_SRT_WR2;
        end else begin
          a_d     = adv_a;
          b_d     = adv_b;
          pass_d  = adv_pass;
          state_d = adv_more ? S_SRT_RD : S_DONE;
        end
      end
      S_SRT_WR2: begin
        wr_o.en   = 1'b1;
        wr_o.addr = b_q[ADDR_W-1:0];
        wr_o.data = tmp_q;
        a_d       = adv_a;
        b_d       = adv_b;
        pass_d    = adv_pass;
        state_d   = adv_more ? S_SRT_RD : S_DONE;
      end
      S_RD_WAIT: begin
        res_rec_d = rd_a_i;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (out_free_i) begin
          done_o  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q       <= a_d;
    b_q       <= b_d;
    pass_q    <= pass_d;
    odd_q     <= odd_d;
    status_q  <= status_d;
    rec_in_q  <= rec_in_d;
    tmp_q     <= tmp_d;
    res_rec_q <= res_rec_d;
  end

  always_comb begin
    res_o.status = status_q;
    res_o.total  = fill_q;
    res_o.rec    = res_rec_q;
  end

endmodule

// ===== src/record_table_sort_desc.sv =====
// top level of the invoice record table with descending amount sort
//
// channel | direction | handshake               | word
// in      | input     | in_valid_i / in_ready_o  | req_type, record fields, position
// out     | output    | out_valid_o / out_ready_i| status, entry_total, record fields
//
// sort compares in steps that may swap a pair: bubble passes over adjacent
//   pairs for an even count, an interchange sort for an odd count
// the record memory has one write port, so a swap writes its two entries in turn
// reset clears the sequencer state, the record count and the output valid flag; the memory is not cleared
// a finished word waits in the output register while the next request is taken
module record_table_sort_desc (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         req_type_i,
  input  logic signed [rtsd_pkg::ID_W-1:0]   invoice_id_i,
  input  logic signed [rtsd_pkg::DAY_W-1:0]  issue_day_i,
  input  logic [rtsd_pkg::BUYER_W-1:0]       buyer_ref_i,
  input  logic                               is_paid_i,
  input  logic [rtsd_pkg::AMT_W-1:0]         amount_i,
  input  logic [rtsd_pkg::POS_W-1:0]         position_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [1:0]                         status_o,
  output logic [rtsd_pkg::TOTAL_W-1:0]       entry_total_o,
  output logic signed [rtsd_pkg::ID_W-1:0]   out_id_o,
  output logic signed [rtsd_pkg::DAY_W-1:0]  out_day_o,
  output logic [rtsd_pkg::BUYER_W-1:0]       out_buyer_o,
  output logic                               out_paid_o,
  output logic [rtsd_pkg::AMT_W-1:0]         out_amount_o
);
  import rtsd_pkg::*;

  `include "record_table_sort_desc_defines.svh"

  rec_t              rec_in;
  wr_t               wr;
  logic [ADDR_W-1:0] ra, rb;
  rec_t              rd_a, rd_b;
  logic [ID_W-1:0]   key;
  cmp_t              cmp;
  logic              done;
  logic              out_free;
  res_t              res;

  // output register, parts the sequencer from the consumer
  logic              out_valid_q, out_valid_d;
  res_t              out_q, out_d;

  // words on offer that report a full table or an empty position
  logic              full_word;
  logic              empty_word;

  // incoming record as it would be stored by an insert
  always_comb begin
    rec_in.id     = $unsigned(invoice_id_i);
    rec_in.day    = $unsigned(issue_day_i);
    rec_in.buyer  = buyer_ref_i;
    rec_in.paid   = is_paid_i;
    rec_in.amount = amount_i;
  end

  rtsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_i      (req_e'(req_type_i)),
    .rec_i      (rec_in),
    .pos_i      (position_i),
    .wr_o       (wr),
    .ra_o       (ra),
    .rb_o       (rb),
    .rd_a_i     (rd_a),
    .rd_b_i     (rd_b),
    .key_o      (key),
    .cmp_i      (cmp),
    .out_free_i (out_free),
    .done_o     (done),
    .res_o      (res)
  );

  rtsd_store u_store (
    .clk_i  (clk_i),
    .wr_i   (wr),
    .ra_i   (ra),
    .rb_i   (rb),
    .rd_a_o (rd_a),
    .rd_b_o (rd_b)
  );

  // single compare unit, reused by delete search and every sort step
  rtsd_cmp u_cmp (
    .rec_a_i (rd_a),
    .rec_b_i (rd_b),
    .key_i   (key),
    .cmp_o   (cmp)
  );

  // free when empty or being drained this cycle
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (done) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign entry_total_o = TOTAL_W'(out_q.total);
  assign out_id_o      = $signed(out_q.rec.id);
  assign out_day_o     = $signed(out_q.rec.day);
  assign out_buyer_o   = out_q.rec.buyer;
  assign out_paid_o    = out_q.rec.paid;
  assign out_amount_o  = out_q.rec.amount;

  assign full_word  = out_valid_o && (status_o == ST_FULL);
  assign empty_word = out_valid_o && (status_o == ST_EMPTY);

  // the table never reports more records than its depth
  `RTSD_ASSERT_IMP(a_total_bound, clk_i, rst_ni, out_valid_o, out_q.total <= FILL_W'(DEPTH))
  // a full report only comes from a full table
  `RTSD_ASSERT_IMP(a_full_count, clk_i, rst_ni, full_word, out_q.total == FILL_W'(DEPTH))
  // a failed read carries no record
  `RTSD_ASSERT_IMP(a_empty_zero, clk_i, rst_ni, empty_word, out_q.rec == '0)
  // the sequencer is busy right after taking a request
  `RTSD_ASSERT_NXT(a_busy_after, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

endmodule
